FILE: hdl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// shared types and codes for the spi-mode sd card init sequencer
// ----------------------------------------------------------------------------
package sdi_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       card_selected;
    logic       slow_clock;
    logic       done_res;
    logic [1:0] card_type;
    logic [2:0] error_code;
  } out_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_DUMMY, PH_WAIT, PH_FRAME, PH_POLL,
    PH_CMD_REL, PH_OCR, PH_FINAL_REL, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_GO_IDLE, ST_IF_COND, ST_V2_LOOP, ST_READ_OCR,
    ST_V1_PROBE, ST_V1_LOOP, ST_BLOCKLEN
  } stage_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] CFG_READY_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_INIT_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT    = 2'd2;

  localparam logic [1:0] TY_NONE = 2'd0;
  localparam logic [1:0] TY_SD1  = 2'd1;
  localparam logic [1:0] TY_SD2  = 2'd2;
  localparam logic [1:0] TY_SDHC = 2'd3;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_TIMEOUT = 3'd1;
  localparam logic [2:0] E_CMD0    = 3'd2;
  localparam logic [2:0] E_IFCOND  = 3'd3;
  localparam logic [2:0] E_ACMD41  = 3'd4;
  localparam logic [2:0] E_CMD58   = 3'd5;
  localparam logic [2:0] E_CMD8    = 3'd6;
  localparam logic [2:0] E_CMD16   = 3'd7;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_SD_OP    = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
  localparam logic [31:0] ARG_BLOCKLEN = 32'd512;

  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] CRC_DEFAULT = 8'h01;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] CHECK_PAT   = 8'hAA;

  localparam logic [3:0] DUMMY_BYTES = 4'd10;
  localparam logic [3:0] FRAME_BYTES = 4'd6;
  localparam logic [3:0] OCR_BYTES   = 4'd4;

  localparam logic [15:0] READY_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] INIT_TIMEOUT_RST  = 16'd1000;
  localparam logic [7:0]  POLL_LIMIT_RST    = 8'd10;

endpackage

FILE: hdl/sd_spi_card_init_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_spi_card_init_sequencer_core
// spi-mode sd card bring-up: dummy clocks, cmd0, cmd8, acmd41 loop, cmd58,
// cmd16; consumes received bytes and ms ticks, emits the next byte to send
// ----------------------------------------------------------------------------
//  channel | ports                         | carries
//  in      | in_valid, in_stall, in_data   | start / received byte / ms tick
//  out     | out_valid, out_stall, out_data| next tx byte or final report
//  cfg     | cfg_we, cfg_addr, cfg_wdata   | timeouts and poll limit
//
//  one request per cycle while in_stall is low; a request is registered, then
//  its step of the sequencer runs combinationally into the result register
//  a tick or an ignored byte leaves no result
//  in_stall rises only while a request waits on a stalled, full result register
//  reset is synchronous; config registers take their defaults, all control state is cleared
// ----------------------------------------------------------------------------
module sd_spi_card_init_sequencer_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdi_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sdi_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // config
  logic [15:0] ready_to_r, init_to_r;
  logic [7:0]  poll_lim_r;

  // request register and result register
  logic          req_v_r, req_v_nxt;
  sdi_pkg::in_t  req_r;
  logic          res_v_r, res_v_nxt;
  sdi_pkg::out_t res_r, res_nxt;
  logic          out_free, advance, has_res;

  // sequencer state
  sdi_pkg::phase_t phase_r, phase_nxt;
  sdi_pkg::stage_t stage_r, stage_nxt;
  logic [3:0]  bidx_r, bidx_nxt, bidx_inc;
  logic [5:0]  cmd_idx_r, cmd_idx_nxt;
  logic [31:0] cmd_arg_r, cmd_arg_nxt;
  logic        app_r, app_nxt;
  logic [7:0]  ocr_r [4];
  logic [7:0]  ocr3;
  logic        ocr_we;
  logic [TIMER_WIDTH-1:0] rdy_ms_r, rdy_ms_nxt, ini_ms_r, ini_ms_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        sel_r, sel_nxt;
  logic        slow_r, slow_nxt;
  logic [7:0]  poll_r, poll_nxt, poll_dec;
  logic [7:0]  tx_r, tx_nxt;

  // step controls
  logic        done_en;
  logic [7:0]  done_resp;
  logic        issue_en, final_en, ocr_start, err_en;
  sdi_pkg::stage_t issue_stage;
  logic [5:0]  issue_idx;
  logic [31:0] issue_arg;
  logic        issue_app;
  logic [2:0]  err_code;
  logic        rdy_reached, ini_reached;
  logic [7:0]  b;

  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic app,
                                            input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [5:0]  i;
    logic [31:0] v;
    logic [7:0]  r;
    i = app ? sdi_pkg::CMD_APP : idx;
    v = app ? 32'd0 : arg;
    case (k)
      3'd0: r = {2'b01, i};
      3'd1: r = v[31:24];
      3'd2: r = v[23:16];
      3'd3: r = v[15:8];
      3'd4: r = v[7:0];
      default: begin
        if (i == sdi_pkg::CMD_GO_IDLE) r = sdi_pkg::CRC_CMD0;
        else if (i == sdi_pkg::CMD_IF_COND) r = sdi_pkg::CRC_CMD8;
        else r = sdi_pkg::CRC_DEFAULT;
      end
    endcase
    return r;
  endfunction

  assign out_free  = !res_v_r || !out_stall;
  assign advance   = req_v_r && out_free;
  assign in_stall  = req_v_r && !out_free;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  assign b        = req_r.rx_byte;
  assign bidx_inc = bidx_r + 4'd1;
  assign poll_dec = poll_r - 8'd1;
  assign rdy_reached = (CW'(rdy_ms_r) >= CW'(ready_to_r)) || (&rdy_ms_r);
  assign ini_reached = (CW'(ini_ms_r) >= CW'(init_to_r)) || (&ini_ms_r);
  assign ocr3 = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_to_r <= sdi_pkg::READY_TIMEOUT_RST;
      init_to_r  <= sdi_pkg::INIT_TIMEOUT_RST;
      poll_lim_r <= sdi_pkg::POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sdi_pkg::CFG_READY_TIMEOUT: ready_to_r <= cfg_wdata;
        sdi_pkg::CFG_INIT_TIMEOUT:  init_to_r  <= cfg_wdata;
        sdi_pkg::CFG_POLL_LIMIT:    poll_lim_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    req_v_nxt = req_v_r;
    if (in_valid && !in_stall) req_v_nxt = 1'b1;
    else if (advance) req_v_nxt = 1'b0;
  end

  // one step of the sequencer for the registered request
  always_comb begin
    phase_nxt   = phase_r;
    stage_nxt   = stage_r;
    bidx_nxt    = bidx_r;
    cmd_idx_nxt = cmd_idx_r;
    cmd_arg_nxt = cmd_arg_r;
    app_nxt     = app_r;
    rdy_ms_nxt  = rdy_ms_r;
    ini_ms_nxt  = ini_ms_r;
    type_nxt    = type_r;
    err_nxt     = err_r;
    sel_nxt     = sel_r;
    slow_nxt    = slow_r;
    poll_nxt    = poll_r;
    tx_nxt      = tx_r;
    has_res     = 1'b0;
    ocr_we      = 1'b0;
    done_en     = 1'b0;
    done_resp   = sdi_pkg::IDLE_BYTE;
    issue_en    = 1'b0;
    issue_stage = sdi_pkg::ST_GO_IDLE;
    issue_idx   = sdi_pkg::CMD_GO_IDLE;
    issue_arg   = 32'd0;
    issue_app   = 1'b0;
    final_en    = 1'b0;
    ocr_start   = 1'b0;
    err_en      = 1'b0;
    err_code    = sdi_pkg::E_NONE;

    case (req_r.kind)
      sdi_pkg::KIND_TICK: begin
        if (!(&rdy_ms_r)) rdy_ms_nxt = rdy_ms_r + 1'b1;
        if (!(&ini_ms_r)) ini_ms_nxt = ini_ms_r + 1'b1;
      end
      sdi_pkg::KIND_START: begin
        has_res   = 1'b1;
        phase_nxt = sdi_pkg::PH_DUMMY;
        stage_nxt = sdi_pkg::ST_GO_IDLE;
        bidx_nxt  = 4'd0;
        app_nxt   = 1'b0;
        type_nxt  = sdi_pkg::TY_NONE;
        err_nxt   = sdi_pkg::E_NONE;
        sel_nxt   = 1'b0;
        slow_nxt  = 1'b1;
        tx_nxt    = sdi_pkg::IDLE_BYTE;
      end
      sdi_pkg::KIND_BYTE: begin
        if (phase_r != sdi_pkg::PH_IDLE && phase_r != sdi_pkg::PH_DONE) begin
          has_res = 1'b1;
          case (phase_r)
            sdi_pkg::PH_DUMMY: begin
              bidx_nxt = bidx_inc;
              if (bidx_inc < sdi_pkg::DUMMY_BYTES) tx_nxt = sdi_pkg::IDLE_BYTE;
              else begin
                issue_en    = 1'b1;
                issue_stage = sdi_pkg::ST_GO_IDLE;
                issue_idx   = sdi_pkg::CMD_GO_IDLE;
              end
            end
            sdi_pkg::PH_WAIT: begin
              if (b == sdi_pkg::IDLE_BYTE) begin
                phase_nxt = sdi_pkg::PH_FRAME;
                bidx_nxt  = 4'd0;
                tx_nxt    = frame_byte(3'd0, app_r, cmd_idx_r, cmd_arg_r);
              end else if (!rdy_reached) begin
                tx_nxt = sdi_pkg::IDLE_BYTE;
              end else begin
                err_en    = 1'b1;
                err_code  = sdi_pkg::E_TIMEOUT;
                phase_nxt = sdi_pkg::PH_CMD_REL;
                sel_nxt   = 1'b0;
                tx_nxt    = sdi_pkg::IDLE_BYTE;
              end
            end
            sdi_pkg::PH_FRAME: begin
              bidx_nxt = bidx_inc;
              if (bidx_inc < sdi_pkg::FRAME_BYTES) begin
                tx_nxt = frame_byte(bidx_inc[2:0], app_r, cmd_idx_r, cmd_arg_r);
              end else begin
                phase_nxt = sdi_pkg::PH_POLL;
                poll_nxt  = poll_lim_r;
                tx_nxt    = sdi_pkg::IDLE_BYTE;
              end
            end
            sdi_pkg::PH_POLL: begin
              poll_nxt = poll_dec;
              if (b[7] && poll_dec != 8'd0) begin
                tx_nxt = sdi_pkg::IDLE_BYTE;
              end else if (app_r) begin
                app_nxt = 1'b0;
                if (b > sdi_pkg::R1_IDLE) begin
                  done_en   = 1'b1;
                  done_resp = b;
                end else begin
                  phase_nxt  = sdi_pkg::PH_WAIT;
                  sel_nxt    = 1'b1;
                  rdy_ms_nxt = '0;
                  tx_nxt     = sdi_pkg::IDLE_BYTE;
                end
              end else begin
                done_en   = 1'b1;
                done_resp = b;
              end
            end
            sdi_pkg::PH_CMD_REL: begin
              app_nxt   = 1'b0;
              done_en   = 1'b1;
              done_resp = sdi_pkg::IDLE_BYTE;
            end
            sdi_pkg::PH_OCR: begin
              ocr_we   = 1'b1;
              bidx_nxt = bidx_inc;
              if (bidx_inc < sdi_pkg::OCR_BYTES) tx_nxt = sdi_pkg::IDLE_BYTE;
              else if (stage_r == sdi_pkg::ST_IF_COND) begin
                if (ocr_r[2] == sdi_pkg::R1_IDLE && ocr3 == sdi_pkg::CHECK_PAT) begin
                  issue_en    = 1'b1;
                  issue_stage = sdi_pkg::ST_V2_LOOP;
                  issue_idx   = sdi_pkg::CMD_SD_OP;
                  issue_arg   = sdi_pkg::ARG_HCS;
                  issue_app   = 1'b1;
                end else begin
                  err_en   = 1'b1;
                  err_code = sdi_pkg::E_IFCOND;
                  final_en = 1'b1;
                end
              end else if (ocr_r[0][6]) begin
                type_nxt = sdi_pkg::TY_SDHC;
                final_en = 1'b1;
              end else begin
                type_nxt    = sdi_pkg::TY_SD2;
                issue_en    = 1'b1;
                issue_stage = sdi_pkg::ST_BLOCKLEN;
                issue_idx   = sdi_pkg::CMD_BLOCKLEN;
                issue_arg   = sdi_pkg::ARG_BLOCKLEN;
              end
            end
            default: begin
              phase_nxt = sdi_pkg::PH_DONE;
              sel_nxt   = 1'b0;
              slow_nxt  = 1'b0;
              if (type_r != sdi_pkg::TY_NONE) err_nxt = sdi_pkg::E_NONE;
              else if (err_r == sdi_pkg::E_NONE) err_nxt = sdi_pkg::E_TIMEOUT;
            end
          endcase
        end
      end
      default: ;
    endcase

    // response handling for the command just finished
    if (done_en) begin
      case (stage_r)
        sdi_pkg::ST_GO_IDLE: begin
          if (done_resp == sdi_pkg::R1_IDLE) begin
            ini_ms_nxt  = '0;
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_IF_COND;
            issue_idx   = sdi_pkg::CMD_IF_COND;
            issue_arg   = sdi_pkg::ARG_IF_COND;
          end else begin
            err_en   = 1'b1;
            err_code = sdi_pkg::E_CMD0;
            final_en = 1'b1;
          end
        end
        sdi_pkg::ST_IF_COND: begin
          if (done_resp == sdi_pkg::R1_IDLE) ocr_start = 1'b1;
          else begin
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_V1_PROBE;
            issue_idx   = sdi_pkg::CMD_SD_OP;
            issue_app   = 1'b1;
          end
        end
        sdi_pkg::ST_V2_LOOP: begin
          if (done_resp == 8'd0) begin
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_READ_OCR;
            issue_idx   = sdi_pkg::CMD_READ_OCR;
          end else if (!ini_reached) begin
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_V2_LOOP;
            issue_idx   = sdi_pkg::CMD_SD_OP;
            issue_arg   = sdi_pkg::ARG_HCS;
            issue_app   = 1'b1;
          end else begin
            err_en   = 1'b1;
            err_code = sdi_pkg::E_ACMD41;
            final_en = 1'b1;
          end
        end
        sdi_pkg::ST_READ_OCR: begin
          if (done_resp == 8'd0) ocr_start = 1'b1;
          else begin
            err_en   = 1'b1;
            err_code = sdi_pkg::E_CMD58;
            final_en = 1'b1;
          end
        end
        sdi_pkg::ST_V1_PROBE: begin
          if (done_resp <= sdi_pkg::R1_IDLE) begin
            type_nxt    = sdi_pkg::TY_SD1;
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_V1_LOOP;
            issue_idx   = sdi_pkg::CMD_SD_OP;
            issue_app   = 1'b1;
          end else begin
            type_nxt = sdi_pkg::TY_NONE;
            err_en   = 1'b1;
            err_code = sdi_pkg::E_CMD8;
            final_en = 1'b1;
          end
        end
        sdi_pkg::ST_V1_LOOP: begin
          if (done_resp == 8'd0) begin
            if (type_r == sdi_pkg::TY_SD1 || type_r == sdi_pkg::TY_SD2) begin
              issue_en    = 1'b1;
              issue_stage = sdi_pkg::ST_BLOCKLEN;
              issue_idx   = sdi_pkg::CMD_BLOCKLEN;
              issue_arg   = sdi_pkg::ARG_BLOCKLEN;
            end else begin
              final_en = 1'b1;
            end
          end else if (!ini_reached) begin
            issue_en    = 1'b1;
            issue_stage = sdi_pkg::ST_V1_LOOP;
            issue_idx   = sdi_pkg::CMD_SD_OP;
            issue_app   = 1'b1;
          end else begin
            type_nxt = sdi_pkg::TY_NONE;
            err_en   = 1'b1;
            err_code = sdi_pkg::E_ACMD41;
            final_en = 1'b1;
          end
        end
        default: begin
          if (done_resp != 8'd0) begin
            type_nxt = sdi_pkg::TY_NONE;
            err_en   = 1'b1;
            err_code = sdi_pkg::E_CMD16;
          end
          final_en = 1'b1;
        end
      endcase
    end

    if (err_en && err_r == sdi_pkg::E_NONE) err_nxt = err_code;
    if (issue_en) begin
      stage_nxt   = issue_stage;
      cmd_idx_nxt = issue_idx;
      cmd_arg_nxt = issue_arg;
      app_nxt     = issue_app;
      phase_nxt   = sdi_pkg::PH_WAIT;
      sel_nxt     = 1'b1;
      rdy_ms_nxt  = '0;
      tx_nxt      = sdi_pkg::IDLE_BYTE;
    end
    if (final_en) begin
      phase_nxt = sdi_pkg::PH_FINAL_REL;
      sel_nxt   = 1'b0;
      tx_nxt    = sdi_pkg::IDLE_BYTE;
    end
    if (ocr_start) begin
      phase_nxt = sdi_pkg::PH_OCR;
      bidx_nxt  = 4'd0;
      tx_nxt    = sdi_pkg::IDLE_BYTE;
    end

    if (phase_nxt == sdi_pkg::PH_DONE) begin
      res_nxt = '{tx_valid: 1'b0, tx_byte: 8'd0, card_selected: 1'b0,
                  slow_clock: 1'b0, done_res: 1'b1, card_type: type_nxt,
                  error_code: err_nxt};
    end else begin
      res_nxt = '{tx_valid: 1'b1, tx_byte: tx_nxt, card_selected: sel_nxt,
                  slow_clock: slow_nxt, done_res: 1'b0,
                  card_type: sdi_pkg::TY_NONE, error_code: sdi_pkg::E_NONE};
    end
  end

  always_comb begin
    res_v_nxt = res_v_r;
    if (advance && has_res) res_v_nxt = 1'b1;
    else if (res_v_r && !out_stall) res_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r   <= 1'b0;
      res_v_r   <= 1'b0;
      phase_r   <= sdi_pkg::PH_IDLE;
      stage_r   <= sdi_pkg::ST_GO_IDLE;
      bidx_r    <= 4'd0;
      cmd_idx_r <= 6'd0;
      cmd_arg_r <= 32'd0;
      app_r     <= 1'b0;
      rdy_ms_r  <= '0;
      ini_ms_r  <= '0;
      type_r    <= sdi_pkg::TY_NONE;
      err_r     <= sdi_pkg::E_NONE;
      sel_r     <= 1'b0;
      slow_r    <= 1'b0;
      poll_r    <= 8'd0;
      tx_r      <= 8'd0;
    end else begin
      req_v_r <= req_v_nxt;
      res_v_r <= res_v_nxt;
      if (advance) begin
        phase_r   <= phase_nxt;
        stage_r   <= stage_nxt;
        bidx_r    <= bidx_nxt;
        cmd_idx_r <= cmd_idx_nxt;
        cmd_arg_r <= cmd_arg_nxt;
        app_r     <= app_nxt;
        rdy_ms_r  <= rdy_ms_nxt;
        ini_ms_r  <= ini_ms_nxt;
        type_r    <= type_nxt;
        err_r     <= err_nxt;
        sel_r     <= sel_nxt;
        slow_r    <= slow_nxt;
        poll_r    <= poll_nxt;
        tx_r      <= tx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_data;
    if (advance && has_res) res_r <= res_nxt;
    if (advance && ocr_we) ocr_r[bidx_r[1:0]] <= b;
  end

  a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sdi_pkg::PH_DONE |-> !sel_r && !slow_r)
    else $error("done with card selected or slow clock on");

  a_dummy_deselected: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sdi_pkg::PH_DUMMY |-> slow_r && !sel_r)
    else $error("dummy clocks with card selected or fast clock");

  a_wait_selected: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sdi_pkg::PH_WAIT |-> sel_r)
    else $error("ready wait with card deselected");

  a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
    (req_v_r && !out_free) |=> req_v_r)
    else $error("request dropped while result register full");

endmodule
